[hw/rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB color conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    typedef struct packed {
        logic [11:0] hue_tenths;
        logic [9:0]  sat_tenths;
        logic [9:0]  val_tenths;
    } hsv_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_rsp_t;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
        logic e;
        logic f;
    } pipe_en_t;

    typedef logic signed [31:0] chan_num_t;

    localparam logic [11:0]        HUE_TURN    = 12'd3600;
    localparam logic [11:0]        SECTOR_SPAN = 12'd600;
    localparam logic signed [20:0] UNIT_NUM    = 21'sd600000;
    localparam chan_num_t          FULL_NUM    = 32'sd600000000;
    localparam logic [5:0]         LEVEL_MUL   = 6'd17;
    localparam logic [15:0]        RECIP_K     = 16'd54976;
    localparam logic [16:0]        RECIP_DIV   = 17'd78125;

endpackage

[hw/rtl/hsv2rgb_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_stream_if
// Valid/ready request channel with a typed payload.
// ----------------------------------------------------------------------------
interface hsv2rgb_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[hw/rtl/hsv2rgb_sector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Hue wrap, sector decode and in-sector fraction (first pipeline stage).
// ----------------------------------------------------------------------------
module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic     clk,
    input  logic     adv,
    input  hsv_req_t req,
    output sector_t  sector,
    output logic [9:0] frac,
    output logic [9:0] sat,
    output logic [9:0] val
);

    logic [11:0] hue_wrap;
    logic [11:0] base;
    sector_t     sector_next;
    logic [9:0]  frac_next;

    sector_t    sector_reg;
    logic [9:0] frac_reg;
    logic [9:0] sat_reg;
    logic [9:0] val_reg;

    always_comb
    begin
        hue_wrap = (req.hue_tenths >= HUE_TURN) ? 12'd0 : req.hue_tenths;
        if (hue_wrap >= 12'(5 * SECTOR_SPAN))
        begin
            sector_next = SEC_MAGENTA;
            base        = 12'(5 * SECTOR_SPAN);
        end
        else if (hue_wrap >= 12'(4 * SECTOR_SPAN))
        begin
            sector_next = SEC_BLUE;
            base        = 12'(4 * SECTOR_SPAN);
        end
        else if (hue_wrap >= 12'(3 * SECTOR_SPAN))
        begin
            sector_next = SEC_CYAN;
            base        = 12'(3 * SECTOR_SPAN);
        end
        else if (hue_wrap >= 12'(2 * SECTOR_SPAN))
        begin
            sector_next = SEC_GREEN;
            base        = 12'(2 * SECTOR_SPAN);
        end
        else if (hue_wrap >= SECTOR_SPAN)
        begin
            sector_next = SEC_YELLOW;
            base        = SECTOR_SPAN;
        end
        else
        begin
            sector_next = SEC_RED;
            base        = 12'd0;
        end
        frac_next = 10'(hue_wrap - base);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sector_reg <= sector_next;
            frac_reg   <= frac_next;
            sat_reg    <= req.sat_tenths;
            val_reg    <= req.val_tenths;
        end
    end

    assign sector = sector_reg;
    assign frac   = frac_reg;
    assign sat    = sat_reg;
    assign val    = val_reg;

endmodule

[hw/rtl/hsv2rgb_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Saturation products, six-way channel select and value scaling (two stages).
// Each channel leaves as a numerator over 600000000.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       adv_b,
    input  logic       adv_c,
    input  sector_t    sector,
    input  logic [9:0] frac,
    input  logic [9:0] sat,
    input  logic [9:0] val,
    output chan_num_t  num_red,
    output chan_num_t  num_green,
    output chan_num_t  num_blue
);

    logic [19:0] prod_p_next;
    logic [19:0] prod_q_next;
    logic [19:0] prod_t_next;

    logic [19:0] prod_p_reg;
    logic [19:0] prod_q_reg;
    logic [19:0] prod_t_reg;
    sector_t     sector_reg;
    logic [9:0]  val_reg;

    logic [19:0]        sub_red;
    logic [19:0]        sub_green;
    logic [19:0]        sub_blue;
    logic signed [20:0] x_red;
    logic signed [20:0] x_green;
    logic signed [20:0] x_blue;
    logic signed [10:0] val_s;
    chan_num_t          num_red_next;
    chan_num_t          num_green_next;
    chan_num_t          num_blue_next;

    chan_num_t num_red_reg;
    chan_num_t num_green_reg;
    chan_num_t num_blue_reg;

    always_comb
    begin
        prod_p_next = 20'(sat) * 20'(SECTOR_SPAN);
        prod_q_next = 20'(sat) * 20'(frac);
        prod_t_next = 20'(sat) * 20'(10'(SECTOR_SPAN) - frac);
    end

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            prod_p_reg <= prod_p_next;
            prod_q_reg <= prod_q_next;
            prod_t_reg <= prod_t_next;
            sector_reg <= sector;
            val_reg    <= val;
        end
    end

    always_comb
    begin
        unique case (sector_reg)
            SEC_RED:
            begin
                sub_red   = 20'd0;
                sub_green = prod_t_reg;
                sub_blue  = prod_p_reg;
            end
            SEC_YELLOW:
            begin
                sub_red   = prod_q_reg;
                sub_green = 20'd0;
                sub_blue  = prod_p_reg;
            end
            SEC_GREEN:
            begin
                sub_red   = prod_p_reg;
                sub_green = 20'd0;
                sub_blue  = prod_t_reg;
            end
            SEC_CYAN:
            begin
                sub_red   = prod_p_reg;
                sub_green = prod_q_reg;
                sub_blue  = 20'd0;
            end
            SEC_BLUE:
            begin
                sub_red   = prod_t_reg;
                sub_green = prod_p_reg;
                sub_blue  = 20'd0;
            end
            default:
            begin
                // magenta sector
                sub_red   = 20'd0;
                sub_green = prod_p_reg;
                sub_blue  = prod_q_reg;
            end
        endcase
        x_red          = UNIT_NUM - signed'({1'b0, sub_red});
        x_green        = UNIT_NUM - signed'({1'b0, sub_green});
        x_blue         = UNIT_NUM - signed'({1'b0, sub_blue});
        val_s          = signed'({1'b0, val_reg});
        num_red_next   = chan_num_t'(val_s) * chan_num_t'(x_red);
        num_green_next = chan_num_t'(val_s) * chan_num_t'(x_green);
        num_blue_next  = chan_num_t'(val_s) * chan_num_t'(x_blue);
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            num_red_reg   <= num_red_next;
            num_green_reg <= num_green_next;
            num_blue_reg  <= num_blue_next;
        end
    end

    assign num_red   = num_red_reg;
    assign num_green = num_green_reg;
    assign num_blue  = num_blue_reg;

endmodule

[hw/rtl/hsv2rgb_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Channel level: floor(255 * num / 600000000), held to 0..255, in three stages
// by reciprocal multiply with a one-step correction.
// ----------------------------------------------------------------------------
module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       adv_d,
    input  logic       adv_e,
    input  logic       adv_f,
    input  chan_num_t  num,
    output logic [7:0] level
);

    logic [33:0] scaled;
    logic        low_next;
    logic        high_next;
    logic [24:0] quo_next;

    logic        low_d_reg;
    logic        high_d_reg;
    logic [24:0] quo_d_reg;

    logic [40:0] recip_prod;
    logic [8:0]  est_next;

    logic        low_e_reg;
    logic        high_e_reg;
    logic [24:0] quo_e_reg;
    logic [8:0]  est_e_reg;

    logic [25:0] back_prod;
    logic [8:0]  fixed_est;
    logic [7:0]  level_next;
    logic [7:0]  level_reg;

    always_comb
    begin
        low_next  = num[31] || (num == '0);
        high_next = (num >= FULL_NUM);
        scaled    = 34'(num[29:0]) * 34'(LEVEL_MUL);
        quo_next  = scaled[33:9];
    end

    always_ff @(posedge clk)
    begin
        if (adv_d)
        begin
            low_d_reg  <= low_next;
            high_d_reg <= high_next;
            quo_d_reg  <= quo_next;
        end
    end

    always_comb
    begin
        recip_prod = 41'(quo_d_reg) * 41'(RECIP_K);
        est_next   = recip_prod[40:32];
    end

    always_ff @(posedge clk)
    begin
        if (adv_e)
        begin
            low_e_reg  <= low_d_reg;
            high_e_reg <= high_d_reg;
            quo_e_reg  <= quo_d_reg;
            est_e_reg  <= est_next;
        end
    end

    always_comb
    begin
        back_prod = 26'(est_e_reg) * 26'(RECIP_DIV);
        fixed_est = (back_prod > 26'(quo_e_reg)) ? (est_e_reg - 9'd1) : est_e_reg;
        if (high_e_reg)
        begin
            level_next = 8'hFF;
        end
        else if (low_e_reg)
        begin
            level_next = 8'h00;
        end
        else
        begin
            level_next = fixed_est[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_f)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[hw/rtl/hsv_to_rgb_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Throughput: one request per cycle when the output is not stalled, set by the
// six-stage register pipeline.
// Each stage advances when empty or when the stage after it advances.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    hsv2rgb_stream_if.sink     hsv,
    hsv2rgb_stream_if.source   rgb
);

    pipe_en_t   en;
    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    sector_t    sector_a;
    logic [9:0] frac_a;
    logic [9:0] sat_a;
    logic [9:0] val_a;
    chan_num_t  num_red_c;
    chan_num_t  num_green_c;
    chan_num_t  num_blue_c;
    logic [7:0] red_f;
    logic [7:0] green_f;
    logic [7:0] blue_f;

    always_comb
    begin
        en.f = !vld_reg[5] || rgb.ready;
        en.e = !vld_reg[4] || en.f;
        en.d = !vld_reg[3] || en.e;
        en.c = !vld_reg[2] || en.d;
        en.b = !vld_reg[1] || en.c;
        en.a = !vld_reg[0] || en.b;
    end

    always_comb
    begin
        vld_next[0] = en.a ? hsv.valid  : vld_reg[0];
        vld_next[1] = en.b ? vld_reg[0] : vld_reg[1];
        vld_next[2] = en.c ? vld_reg[1] : vld_reg[2];
        vld_next[3] = en.d ? vld_reg[2] : vld_reg[3];
        vld_next[4] = en.e ? vld_reg[3] : vld_reg[4];
        vld_next[5] = en.f ? vld_reg[4] : vld_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    hsv2rgb_sector u_sector (
        .clk    (clk),
        .adv    (en.a),
        .req    (hsv.data),
        .sector (sector_a),
        .frac   (frac_a),
        .sat    (sat_a),
        .val    (val_a)
    );

    hsv2rgb_mix u_mix (
        .clk       (clk),
        .adv_b     (en.b),
        .adv_c     (en.c),
        .sector    (sector_a),
        .frac      (frac_a),
        .sat       (sat_a),
        .val       (val_a),
        .num_red   (num_red_c),
        .num_green (num_green_c),
        .num_blue  (num_blue_c)
    );

    hsv2rgb_scale u_scale_red (
        .clk   (clk),
        .adv_d (en.d),
        .adv_e (en.e),
        .adv_f (en.f),
        .num   (num_red_c),
        .level (red_f)
    );

    hsv2rgb_scale u_scale_green (
        .clk   (clk),
        .adv_d (en.d),
        .adv_e (en.e),
        .adv_f (en.f),
        .num   (num_green_c),
        .level (green_f)
    );

    hsv2rgb_scale u_scale_blue (
        .clk   (clk),
        .adv_d (en.d),
        .adv_e (en.e),
        .adv_f (en.f),
        .num   (num_blue_c),
        .level (blue_f)
    );

    assign hsv.ready      = en.a;
    assign rgb.valid      = vld_reg[5];
    assign rgb.data.red   = red_f;
    assign rgb.data.green = green_f;
    assign rgb.data.blue  = blue_f;

endmodule

[hw/rtl/hsv2rgb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     hsv_valid,
    input logic     hsv_ready,
    input hsv_req_t hsv_data,
    input logic     rgb_valid,
    input logic     rgb_ready,
    input rgb_rsp_t rgb_data
);

    logic hsv_fire;

    assign hsv_fire = hsv_valid && hsv_ready;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb_data))
        else $error("stalled result changed or dropped");

    // a request with a free output path arrives as a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_fire ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
        ##1 rgb_ready |=> rgb_valid)
        else $error("result missing after pipeline latency");

    // red-to-yellow sector keeps red >= green >= blue
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_fire && (hsv_data.hue_tenths < 12'd600)) ##1 rgb_ready ##1 rgb_ready
        ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
        |=> (rgb_data.red >= rgb_data.green) && (rgb_data.green >= rgb_data.blue))
        else $error("channel order wrong in first hue sector");

    // zero value gives black
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_fire && (hsv_data.val_tenths == 10'd0)) ##1 rgb_ready ##1 rgb_ready
        ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready
        |=> (rgb_data.red == 8'd0) && (rgb_data.green == 8'd0)
            && (rgb_data.blue == 8'd0))
        else $error("zero value did not give black");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_valid (hsv.valid),
    .hsv_ready (hsv.ready),
    .hsv_data  (hsv.data),
    .rgb_valid (rgb.valid),
    .rgb_ready (rgb.ready),
    .rgb_data  (rgb.data)
);
